// File: sv/quadrature_rotary_decoder_assert.svh
// Assertion macros for the quadrature rotary decoder.
// Used by the top level only; needs nothing else.
`ifndef QUADRATURE_ROTARY_DECODER_ASSERT_SVH
`define QUADRATURE_ROTARY_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QRD_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define QRD_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/qrd_pkg.sv
// Shared types and constants of the quadrature rotary decoder.
// No dependencies; used by all modules of the block.
`timescale 1ns / 1ps

package qrd_pkg;

    localparam int NUM_LINES = 2;           // encoder lines per sample
    localparam int POS_W     = 16;          // position and step count width
    localparam int DIR_W     = 3;           // signed direction width
    localparam int CFG_IDX_W = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLLOVER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINARY     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 2'd3;

    localparam logic [POS_W-1:0] STEP_COUNT_RESET = 16'd24;

    // Period modes
    typedef enum logic [1:0] {
        MODE_FULL     = 2'd0,
        MODE_HALF     = 2'd1,
        MODE_QUARTER  = 2'd2,
        MODE_RESERVED = 2'd3
    } period_mode_t;

    localparam logic [DIR_W-1:0] DIR_CW  = 3'b001;
    localparam logic [DIR_W-1:0] DIR_CCW = 3'b111;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } ctrl_state_t;

    // Decoder state after one sample, plus the fire decision
    typedef struct packed {
        logic             fire;
        logic [DIR_W-1:0] direction;
        logic             armed;
        logic [1:0]       stable;
        logic             primed;
    } decode_t;

endpackage

// File: sv/qrd_step_decode.sv
// Step decoder of the quadrature rotary decoder: line decode and the
// full, half and quarter period step rules. Depends on qrd_pkg.
`timescale 1ns / 1ps

module qrd_step_decode (
    input  logic [qrd_pkg::NUM_LINES-1:0] line_levels,
    input  logic                          binary_lines,
    input  qrd_pkg::period_mode_t         period_mode,
    input  logic [qrd_pkg::DIR_W-1:0]     direction,
    input  logic                          armed,
    input  logic [1:0]                    stable,
    input  logic                          primed,
    output qrd_pkg::decode_t              dec
);

    logic [1:0] s;
    logic [1:0] half_d;

    always_comb begin
        s[1] = line_levels[1];
        s[0] = line_levels[0] ^ (line_levels[1] & ~binary_lines);
        half_d = stable - s + 2'd1;

        dec.fire      = 1'b0;
        dec.direction = direction;
        dec.armed     = armed;
        dec.stable    = stable;
        dec.primed    = primed;

        unique case (period_mode)
            qrd_pkg::MODE_FULL: begin
                if (s == 2'd0) begin
                    if (armed) begin
                        dec.fire  = 1'b1;
                        dec.armed = 1'b0;
                    end
                end else if (s == 2'd2) begin
                    dec.armed = 1'b1;
                end else if (armed) begin
                    dec.direction = (s == 2'd1) ? qrd_pkg::DIR_CW : qrd_pkg::DIR_CCW;
                end
            end
            qrd_pkg::MODE_HALF: begin
                if (!primed) begin
                    dec.stable = s;
                    dec.primed = 1'b1;
                end else if (s[0]) begin
                    // odd state: remember which way the last edge went
                    dec.direction = {1'b0, half_d} - 3'd1;
                end else if (s != stable) begin
                    dec.fire   = 1'b1;
                    dec.stable = s;
                end
            end
            qrd_pkg::MODE_QUARTER: begin
                if (!primed) begin
                    dec.stable = s;
                    dec.primed = 1'b1;
                end else begin
                    if (stable + 2'd1 == s) begin
                        dec.direction = qrd_pkg::DIR_CW;
                        dec.fire      = 1'b1;
                    end else if (stable == s + 2'd1) begin
                        dec.direction = qrd_pkg::DIR_CCW;
                        dec.fire      = 1'b1;
                    end
                    dec.stable = s;
                end
            end
            qrd_pkg::MODE_RESERVED: begin
                // ignore the sample
            end
            default: begin
            end
        endcase
    end

endmodule

// File: sv/qrd_rem_unit.sv
// Iterative remainder unit: one restoring shift-subtract step per cycle.
// Depends on qrd_pkg for the position width.
`timescale 1ns / 1ps

module qrd_rem_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [qrd_pkg::POS_W:0]   dividend,
    input  logic [qrd_pkg::POS_W-1:0] divisor,
    output logic                      done,
    output logic [qrd_pkg::POS_W-1:0] remainder
);

    localparam int STEPS = qrd_pkg::POS_W + 1;
    localparam int CNT_W = $clog2(STEPS);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [qrd_pkg::POS_W-1:0] rem_reg, rem_next;
    logic [qrd_pkg::POS_W:0]   dvd_reg, dvd_next;
    logic [qrd_pkg::POS_W-1:0] dvs_reg, dvs_next;

    logic [qrd_pkg::POS_W:0]   shifted;
    logic [qrd_pkg::POS_W:0]   diff;
    logic                      ge;

    always_comb begin
        shifted = {rem_reg, dvd_reg[qrd_pkg::POS_W]};
        ge      = shifted >= {1'b0, dvs_reg};
        diff    = shifted - {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // partial remainder stays below the divisor, so 16 bits hold it
            rem_next = ge ? diff[qrd_pkg::POS_W-1:0] : shifted[qrd_pkg::POS_W-1:0];
            dvd_next = {dvd_reg[qrd_pkg::POS_W-1:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: sv/quadrature_rotary_decoder.sv
// Quadrature rotary decoder, top level: sequencer, position update and
// stream ports. Uses qrd_pkg, qrd_step_decode, qrd_rem_unit and the assert header.
//
// Usage: each input item on s_* is one sample of the encoder lines taken at a
// line edge. A sample that fires a step gives one result item on m_*: the new
// position and the signed step direction; other samples give nothing.
// Configuration (step count, rollover, Gray or binary lines, period mode) is
// written through cfg_we / cfg_addr / cfg_wdata while the block is idle.
// Timing: a sample that gives no result leaves the block idle, and the next
// can follow at once. A step without a wrap passes from the idle state to the
// emit state, which loads the output register and raises m_tvalid, and the
// next sample is taken when the block is back in idle. With rollover and a
// nonzero step count the wrap goes through the remainder unit in the divide
// state, one quotient bit per cycle over 17 bits. No new sample is taken until
// the result sits in the output register. Reset clears position, direction and
// decoder state and loads the configuration defaults (24 steps, clamp, Gray
// lines, full period). When the receiver stalls, the result holds in the output
// register; a further step waits in the sequencer until the register frees up.
`timescale 1ns / 1ps

module quadrature_rotary_decoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [qrd_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [qrd_pkg::POS_W-1:0]          cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [qrd_pkg::IN_TDATA_W-1:0]     s_tdata,   // [1:0] line_levels
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [qrd_pkg::OUT_TDATA_W-1:0]    m_tdata    // [15:0] position, [18:16] step_value
);

`include "quadrature_rotary_decoder_assert.svh"

    localparam int POS_W = qrd_pkg::POS_W;

    // configuration
    logic [POS_W-1:0]          step_count_reg;
    logic                      rollover_reg;
    logic                      binary_reg;
    qrd_pkg::period_mode_t     mode_reg;

    // decoder state
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [qrd_pkg::DIR_W-1:0] dir_reg, dir_next;
    logic                      armed_reg, armed_next;
    logic [1:0]                stable_reg, stable_next;
    logic                      primed_reg, primed_next;

    qrd_pkg::ctrl_state_t      state_reg, state_next;
    logic [POS_W-1:0]          res_pos_reg, res_pos_next;
    logic [qrd_pkg::DIR_W-1:0] res_dir_reg, res_dir_next;
    logic                      m_valid_reg, m_valid_next;
    logic [POS_W-1:0]          out_pos_reg, out_pos_next;
    logic [qrd_pkg::DIR_W-1:0] out_dir_reg, out_dir_next;

    qrd_pkg::decode_t          dec;
    logic                      s_accept;
    logic                      out_free;
    logic                      use_div;
    logic [POS_W:0]            wrap_sum;
    logic [POS_W:0]            dividend;
    logic [POS_W-1:0]          clamp_pos;
    logic                      rem_start;
    logic                      rem_done;
    logic [POS_W-1:0]          rem_value;

    qrd_step_decode u_decode (
        .line_levels  (s_tdata[qrd_pkg::NUM_LINES-1:0]),
        .binary_lines (binary_reg),
        .period_mode  (mode_reg),
        .direction    (dir_reg),
        .armed        (armed_reg),
        .stable       (stable_reg),
        .primed       (primed_reg),
        .dec          (dec)
    );

    qrd_rem_unit u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (dividend),
        .divisor   (step_count_reg),
        .done      (rem_done),
        .remainder (rem_value)
    );

    assign s_tready = (state_reg == qrd_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign use_div  = rollover_reg && (step_count_reg != '0);

    // position before the wrap, and the clamped position
    always_comb begin
        if (dec.direction[qrd_pkg::DIR_W-1]) begin
            wrap_sum  = {1'b0, pos_reg} + {1'b0, step_count_reg};
            dividend  = (wrap_sum != '0) ? wrap_sum - (POS_W+1)'(1) : wrap_sum;
            clamp_pos = (pos_reg != '0) ? pos_reg - POS_W'(1) : pos_reg;
        end else begin
            wrap_sum  = {1'b0, pos_reg} + (POS_W+1)'(1);
            dividend  = wrap_sum;
            clamp_pos = (pos_reg < step_count_reg) ? pos_reg + POS_W'(1) : pos_reg;
        end
    end

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        dir_next     = dir_reg;
        armed_next   = armed_reg;
        stable_next  = stable_reg;
        primed_next  = primed_reg;
        res_pos_next = res_pos_reg;
        res_dir_next = res_dir_reg;
        out_pos_next = out_pos_reg;
        out_dir_next = out_dir_reg;
        m_valid_next = m_valid_reg && !m_tready;
        rem_start    = 1'b0;

        unique case (state_reg)
            qrd_pkg::ST_IDLE: begin
                if (s_accept) begin
                    dir_next     = dec.direction;
                    armed_next   = dec.armed;
                    stable_next  = dec.stable;
                    primed_next  = dec.primed;
                    if (dec.fire) begin
                        res_dir_next = dec.direction;
                        if (use_div) begin
                            rem_start  = 1'b1;
                            state_next = qrd_pkg::ST_DIV;
                        end else begin
                            // rollover with zero modulus holds at 0
                            res_pos_next = rollover_reg ? '0 : clamp_pos;
                            pos_next     = res_pos_next;
                            state_next   = qrd_pkg::ST_EMIT;
                        end
                    end
                end
            end
            qrd_pkg::ST_DIV: begin
                if (rem_done) begin
                    res_pos_next = rem_value;
                    pos_next     = rem_value;
                    state_next   = qrd_pkg::ST_EMIT;
                end
            end
            qrd_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_pos_next = res_pos_reg;
                    out_dir_next = res_dir_reg;
                    m_valid_next = 1'b1;
                    state_next   = qrd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = qrd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg <= qrd_pkg::STEP_COUNT_RESET;
            rollover_reg   <= 1'b0;
            binary_reg     <= 1'b0;
            mode_reg       <= qrd_pkg::MODE_FULL;
            pos_reg        <= '0;
            dir_reg        <= '0;
            armed_reg      <= 1'b0;
            stable_reg     <= '0;
            primed_reg     <= 1'b0;
            state_reg      <= qrd_pkg::ST_IDLE;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    qrd_pkg::CFG_STEP_COUNT: step_count_reg <= cfg_wdata;
                    qrd_pkg::CFG_ROLLOVER:   rollover_reg   <= cfg_wdata[0];
                    qrd_pkg::CFG_BINARY:     binary_reg     <= cfg_wdata[0];
                    qrd_pkg::CFG_PERIOD:
                        mode_reg <= qrd_pkg::period_mode_t'(cfg_wdata[1:0]);
                    default: begin
                    end
                endcase
            end
            pos_reg     <= pos_next;
            dir_reg     <= dir_next;
            armed_reg   <= armed_next;
            stable_reg  <= stable_next;
            primed_reg  <= primed_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        res_pos_reg <= res_pos_next;
        res_dir_reg <= res_dir_next;
        out_pos_reg <= out_pos_next;
        out_dir_reg <= out_dir_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(qrd_pkg::OUT_TDATA_W - POS_W - qrd_pkg::DIR_W){1'b0}},
                       out_dir_reg, out_pos_reg};

    `QRD_ASSERT_NEXT(a_fire_blocks_input, aclk, aresetn,
        s_accept && dec.fire, !s_tready, "fired step did not hold off input")
    `QRD_ASSERT_SAME(a_rem_below_divisor, aclk, aresetn,
        rem_done, rem_value < step_count_reg, "remainder not below step count")
    `QRD_ASSERT_SAME(a_div_only_wrapping, aclk, aresetn,
        state_reg == qrd_pkg::ST_DIV, use_div, "remainder pass without wrap")

endmodule

// File: sim/tb.sv
// Self-checking testbench for quadrature_rotary_decoder: directed table, then random
// encoder rotation with idling on both stream sides. Depends on qrd_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import qrd_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_ITEMS  = 1150;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [DIR_W-1:0] step;
    } step_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [POS_W-1:0]   value;      // register value, or line levels in [1:0]
        logic               typed;
        logic [POS_W-1:0]   want_pos;
        logic [DIR_W-1:0]   want_step;
    } stim_row_t;

    localparam int NUM_ROWS = 28;
    localparam stim_row_t DIRECTED [0:NUM_ROWS-1] = '{
        // full period, Gray lines: fire with no direction set, then counter-clockwise
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b00, 1'b0, 16'd0, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b11, 1'b0, 16'd0, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b00, 1'b1, 16'd1, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b11, 1'b0, 16'd0, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b10, 1'b0, 16'd0, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b00, 1'b1, 16'd0, DIR_CCW},
        // reserved mode drops samples and does not prime
        '{ROW_WRITE, CFG_PERIOD, 16'(MODE_RESERVED), 1'b0, 16'd0, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b11, 1'b0, 16'd0, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b01, 1'b0, 16'd0, 3'd0},
        // half period primed on an odd state: directions 0 then 2
        '{ROW_WRITE, CFG_PERIOD, 16'(MODE_HALF), 1'b0, 16'd0, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b10, 1'b0, 16'd0, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b10, 1'b0, 16'd0, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b01, 1'b0, 16'd0, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b11, 1'b1, 16'd1, 3'd2},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b01, 1'b0, 16'd0, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b00, 1'b0, 16'd0, 3'd0},
        // quarter period, binary lines, limit 0 below the position
        '{ROW_WRITE, CFG_PERIOD, 16'(MODE_QUARTER), 1'b0, 16'd0, 3'd0},
        '{ROW_WRITE, CFG_BINARY, 16'd1, 1'b0, 16'd0, 3'd0},
        '{ROW_WRITE, CFG_STEP_COUNT, 16'd0, 1'b0, 16'd0, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b01, 1'b1, 16'd2, DIR_CW},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b00, 1'b1, 16'd1, DIR_CCW},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b10, 1'b0, 16'd0, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b10, 1'b0, 16'd0, 3'd0},
        // rollover with a zero modulus holds 0
        '{ROW_WRITE, CFG_ROLLOVER, 16'd1, 1'b0, 16'd0, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b11, 1'b1, 16'd0, DIR_CW},
        // widest modulus: wrap down and back up
        '{ROW_WRITE, CFG_STEP_COUNT, 16'hFFFF, 1'b0, 16'd0, 3'd0},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b10, 1'b1, 16'd65534, DIR_CCW},
        '{ROW_SAMPLE, CFG_STEP_COUNT, 16'b11, 1'b1, 16'd0, DIR_CW}
    };

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr  = '0;
    logic [POS_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Decoder copy: configuration and state
    logic [POS_W-1:0]        step_cnt;
    logic                    roll;
    logic                    bin_lines;
    period_mode_t            pmode;
    logic [POS_W-1:0]        pos_q;
    logic signed [DIR_W-1:0] dir_q;
    logic                    armed_q;
    logic [1:0]              stable_q;
    logic                    primed_q;

    step_result_t expected_steps [$];
    int  mismatches   = 0;
    int  cycle_count  = 0;
    int  samples_sent = 0;
    bit  steady       = 1'b0;

    quadrature_rotary_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void advance_position(output step_result_t res);
        int unsigned p;
        p = pos_q;
        if (dir_q < 0) begin
            if (roll)
                p += step_cnt;
            if (p != 0)
                p--;
        end else if (roll || p < step_cnt) begin
            p++;
        end
        if (roll)
            p = (step_cnt != 0) ? p % step_cnt : 0;
        pos_q = p[POS_W-1:0];
        res.position = pos_q;
        res.step = dir_q;
    endfunction

    // Run one sample through the decoder copy; return 1 when it fires a step
    function automatic bit decode_sample(input logic [1:0] lines, output step_result_t res);
        logic [1:0] s;
        logic [1:0] d;
        logic [1:0] up;
        logic [1:0] down;
        bit fired;
        s = bin_lines ? lines : {lines[1], lines[1] ^ lines[0]};
        fired = 1'b0;
        res = '0;
        if (pmode == MODE_RESERVED)
            return 1'b0;
        if (pmode != MODE_FULL && !primed_q) begin
            stable_q = s;
            primed_q = 1'b1;
            return 1'b0;
        end
        case (pmode)
            MODE_FULL: begin
                if (s == 2'd0) begin
                    if (armed_q) begin
                        advance_position(res);
                        armed_q = 1'b0;
                        fired = 1'b1;
                    end
                end else if (s == 2'd2) begin
                    armed_q = 1'b1;
                end else if (armed_q) begin
                    dir_q = (s == 2'd1) ? $signed(DIR_CW) : $signed(DIR_CCW);
                end
            end
            MODE_HALF: begin
                if (s[0]) begin
                    d = stable_q - s + 2'd1;
                    dir_q = $signed({1'b0, d}) - 3'sd1;
                end else if (s != stable_q) begin
                    advance_position(res);
                    stable_q = s;
                    fired = 1'b1;
                end
            end
            default: begin
                up = stable_q + 2'd1;
                down = s + 2'd1;
                if (up == s) begin
                    dir_q = $signed(DIR_CW);
                    fired = 1'b1;
                end else if (stable_q == down) begin
                    dir_q = $signed(DIR_CCW);
                    fired = 1'b1;
                end
                if (fired)
                    advance_position(res);
                stable_q = s;
            end
        endcase
        return fired;
    endfunction

    task automatic send_lines(input logic [1:0] lines, input bit typed, input step_result_t want);
        step_result_t res;
        bit fired;
        while (!steady && $urandom_range(0, 99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-2){1'b0}}, lines};
        do @(posedge aclk); while (!s_tready);
        fired = decode_sample(lines, res);
        if (typed)
            expected_steps.push_back(want);
        else if (fired)
            expected_steps.push_back(res);
    endtask

    // Stop sending and let the block go idle before a register write
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_steps.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_STEP_COUNT: step_cnt  = val;
            CFG_ROLLOVER:   roll      = val[0];
            CFG_BINARY:     bin_lines = val[0];
            default:        pmode     = period_mode_t'(val[1:0]);
        endcase
    endtask

    always @(posedge aclk)
        m_tready <= steady || ($urandom_range(0, 99) >= 29);

    always @(posedge aclk) begin
        step_result_t head;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_steps.size() == 0) begin
                $error("unexpected result item: position %0d step %0d",
                       m_tdata[15:0], m_tdata[18:16]);
                mismatches++;
            end else begin
                head = expected_steps.pop_front();
                if (m_tdata[15:0] !== head.position) begin
                    $error("position: expected %0d, got %0d", head.position, m_tdata[15:0]);
                    mismatches++;
                end
                if (m_tdata[18:16] !== head.step) begin
                    $error("step_value: expected %0d, got %0d", head.step, m_tdata[18:16]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        step_result_t want;
        bit in_cfg;
        int n_items;
        int pick;
        logic [1:0] angle;
        logic [1:0] spin;
        logic [1:0] lines;

        step_cnt  = STEP_COUNT_RESET;
        roll      = 1'b0;
        bin_lines = 1'b0;
        pmode     = MODE_FULL;
        pos_q     = '0;
        dir_q     = '0;
        armed_q   = 1'b0;
        stable_q  = '0;
        primed_q  = 1'b0;
        in_cfg    = 1'b0;
        angle     = '0;
        spin      = 2'd1;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_WRITE) begin
                if (!in_cfg)
                    settle();
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
                in_cfg = 1'b1;
            end else begin
                if (in_cfg)
                    cfg_we <= 1'b0;
                in_cfg = 1'b0;
                want.position = DIRECTED[i].want_pos;
                want.step = DIRECTED[i].want_step;
                send_lines(DIRECTED[i].value[1:0], DIRECTED[i].typed, want);
            end
        end

        while (samples_sent < RANDOM_ITEMS) begin
            settle();
            pick = $urandom_range(0, 9);
            case (pick)
                0:       write_reg(CFG_STEP_COUNT, 16'd0);
                1:       write_reg(CFG_STEP_COUNT, 16'hFFFF);
                2:       write_reg(CFG_STEP_COUNT, 16'd1);
                8:       write_reg(CFG_STEP_COUNT, 16'($urandom_range(9, 40)));
                9:       write_reg(CFG_STEP_COUNT, 16'($urandom_range(0, 65535)));
                default: write_reg(CFG_STEP_COUNT, 16'($urandom_range(2, 8)));
            endcase
            write_reg(CFG_ROLLOVER, 16'($urandom_range(0, 1)));
            write_reg(CFG_BINARY, 16'($urandom_range(0, 1)));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                write_reg(CFG_PERIOD, 16'(MODE_RESERVED));
            else
                write_reg(CFG_PERIOD, 16'(pick % 3));
            cfg_we <= 1'b0;

            n_items = (pmode == MODE_RESERVED) ? 10 : $urandom_range(30, 90);
            for (int k = 0; k < n_items; k++) begin
                // mostly a steady rotation, with jitter, dwell and line noise
                if ($urandom_range(0, 99) < 5)
                    spin = -spin;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    angle = angle + spin;
                else if (pick < 80)
                    angle = angle - spin;
                else if (pick >= 90)
                    angle = 2'($urandom_range(0, 3));
                lines = bin_lines ? angle : {angle[1], angle[1] ^ angle[0]};
                steady = (samples_sent >= 400 && samples_sent < 600);
                send_lines(lines, 1'b0, '0);
                if (pmode != MODE_RESERVED)
                    samples_sent++;
            end
        end

        settle();
        if (mismatches == 0 && expected_steps.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
